@@ hw/rtl/ris_pkg.sv @@
// Shared types, codes and constants for the roller intake sequencer.
`default_nettype none

package ris_pkg;

    // Width of the microsecond timestamp and the timer stamp
    localparam int TIME_BITS = 40;

    localparam int MV_BITS   = 15;
    localparam int CFG_BITS  = 24;
    localparam int IDX_BITS  = 3;

    typedef logic [TIME_BITS-1:0]      time_t;
    typedef logic signed [MV_BITS-1:0] mv_t;

    // Hold drive for a cone sitting in the rollers
    localparam mv_t HOLD_MV = 15'sd1300;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_INTAKING = 2'd1,
        MODE_LOADED   = 2'd2,
        MODE_SPITTING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PIECE_NONE      = 2'd0,
        PIECE_CONE_UP   = 2'd1,
        PIECE_CONE_DOWN = 2'd2,
        PIECE_CUBE      = 2'd3
    } piece_t;

    typedef enum logic [2:0] {
        GOAL_NONE      = 3'd0,
        GOAL_CONE_UP   = 3'd1,
        GOAL_CONE_DOWN = 3'd2,
        GOAL_CUBE      = 3'd3,
        GOAL_LAST      = 3'd4,
        GOAL_SPIT      = 3'd5
    } goal_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_CURRENT_THRESHOLD = 3'd0,
        REG_POSITION_LIMIT    = 3'd1,
        REG_INTAKE_TIMEOUT    = 3'd2,
        REG_SPIT_TIMEOUT      = 3'd3,
        REG_CUBE_SUCK_MV      = 3'd4,
        REG_CONE_SUCK_MV      = 3'd5,
        REG_CUBE_SPIT_MV      = 3'd6,
        REG_CONE_SPIT_MV      = 3'd7
    } reg_idx_t;

    // One control tick as held in the input register
    typedef struct packed {
        time_t       timestamp;
        logic [2:0]  goal_code;
        logic        preloaded;
        logic        beam_broken;
        logic [11:0] motor_current;
        logic [11:0] cone_pos;
    } tick_t;

endpackage

`default_nettype wire

@@ hw/rtl/ris_if.sv @@
// Valid/ready channel interfaces for ticks in and drive results out.
`default_nettype none

interface ris_tick_if
    import ris_pkg::*;
;
    logic        valid;
    logic        ready;
    time_t       timestamp;
    logic [2:0]  goal_code;
    logic        preloaded;
    logic        beam_broken;
    logic [11:0] motor_current;
    logic [11:0] cone_pos;

    modport source (output valid, timestamp, goal_code, preloaded, beam_broken,
                    motor_current, cone_pos, input ready);
    modport sink   (input valid, timestamp, goal_code, preloaded, beam_broken,
                    motor_current, cone_pos, output ready);
endinterface

interface ris_result_if
    import ris_pkg::*;
;
    logic       valid;
    logic       ready;
    mv_t        roller_mv;
    logic [1:0] mode_out;
    logic [1:0] piece_out;

    modport source (output valid, roller_mv, mode_out, piece_out, input ready);
    modport sink   (input valid, roller_mv, mode_out, piece_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/roller_intake_sequencer_core.sv @@
// Roller intake sequencer: mode and piece tracking with roller drive output.
//
//  channel  | dir | handshake     | beat carries
//  ---------+-----+---------------+-------------------------------------------------
//  tick     | in  | valid/ready   | timestamp, goal_code, preloaded, beam, current, pos
//  result   | out | valid/ready   | roller_mv, mode_out, piece_out
//  cfg      | in  | write enable  | cfg_index, cfg_data (24 bit)
//
// One beat per cycle sustained while the result side is not stalled; a tick is
// captured in the input register, and its result is then registered in the result
// registers and offered from there. The state update sits between the input and
// result registers. Reset clears mode, piece, stamp, last held flag and all
// configuration registers to their defaults. A stalled result holds the input
// register, and a new tick is taken whenever the input register is empty or moves on.
`default_nettype none

module roller_intake_sequencer_core
    import ris_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    ris_tick_if.sink                 tick,
    ris_result_if.source             result,
    input  wire logic                cfg_we,
    input  wire logic [IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    // Configuration registers
    logic [11:0] cur_thresh_reg;
    logic [11:0] pos_limit_reg;
    logic [23:0] intake_to_reg;
    logic [23:0] spit_to_reg;
    mv_t         cube_suck_reg;
    mv_t         cone_suck_reg;
    mv_t         cube_spit_reg;
    mv_t         cone_spit_reg;

    // Sequencer state
    mode_t  mode_reg,  mode_next;
    piece_t piece_reg, piece_next;
    time_t  stamp_reg, stamp_next;
    logic   held_reg,  held_next;

    // Pipeline registers
    logic   in_valid_reg;
    tick_t  in_reg;
    logic   out_valid_reg;
    mv_t    mv_reg, mv_next;
    mode_t  mode_out_reg;
    piece_t piece_out_reg;

    logic   advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_thresh_reg <= 12'd400;
            pos_limit_reg  <= 12'd3768;
            intake_to_reg  <= 24'd2000000;
            spit_to_reg    <= 24'd0;
            cube_suck_reg  <= '0;
            cone_suck_reg  <= '0;
            cube_spit_reg  <= '0;
            cone_spit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CURRENT_THRESHOLD: cur_thresh_reg <= cfg_data[11:0];
                REG_POSITION_LIMIT:    pos_limit_reg  <= cfg_data[11:0];
                REG_INTAKE_TIMEOUT:    intake_to_reg  <= cfg_data;
                REG_SPIT_TIMEOUT:      spit_to_reg    <= cfg_data;
                REG_CUBE_SUCK_MV:      cube_suck_reg  <= mv_t'(cfg_data[MV_BITS-1:0]);
                REG_CONE_SUCK_MV:      cone_suck_reg  <= mv_t'(cfg_data[MV_BITS-1:0]);
                REG_CUBE_SPIT_MV:      cube_spit_reg  <= mv_t'(cfg_data[MV_BITS-1:0]);
                REG_CONE_SPIT_MV:      cone_spit_reg  <= mv_t'(cfg_data[MV_BITS-1:0]);
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_reg.timestamp     <= tick.timestamp;
            in_reg.goal_code     <= tick.goal_code;
            in_reg.preloaded     <= tick.preloaded;
            in_reg.beam_broken   <= tick.beam_broken;
            in_reg.motor_current <= tick.motor_current;
            in_reg.cone_pos      <= tick.cone_pos;
        end
    end

    // Step logic: one tick against the current state
    always_comb
    begin
        goal_t      goal;
        logic       intake_goal;
        mode_t      m;
        piece_t     pk;
        time_t      st;
        time_t      now;
        time_t      elapsed;
        logic [23:0] to;
        logic       expired;
        logic       held;
        mv_t        mv;

        now = in_reg.timestamp;

        // Unused goal codes behave as no goal
        unique case (in_reg.goal_code)
            GOAL_NONE, GOAL_CONE_UP, GOAL_CONE_DOWN, GOAL_CUBE, GOAL_LAST, GOAL_SPIT:
                goal = goal_t'(in_reg.goal_code);
            default:
                goal = GOAL_NONE;
        endcase
        intake_goal = (goal == GOAL_CONE_UP) || (goal == GOAL_CONE_DOWN) ||
                      (goal == GOAL_CUBE) || (goal == GOAL_LAST);

        m  = mode_reg;
        pk = piece_reg;
        st = stamp_reg;
        mv = '0;

        // Preloaded cone skips straight to loaded
        if (in_reg.preloaded && (m == MODE_IDLE || m == MODE_INTAKING))
        begin
            pk = PIECE_CONE_UP;
            m  = MODE_LOADED;
        end

        // Goal selects the piece kind
        if (goal == GOAL_CONE_UP)
            pk = PIECE_CONE_UP;
        else if (goal == GOAL_CONE_DOWN)
            pk = PIECE_CONE_DOWN;
        else if (goal == GOAL_CUBE)
            pk = PIECE_CUBE;

        held = ((pk == PIECE_CUBE || pk == PIECE_CONE_UP) && in_reg.beam_broken) ||
               (pk == PIECE_CONE_DOWN && in_reg.motor_current > cur_thresh_reg &&
                in_reg.cone_pos < pos_limit_reg);

        // Entering spit
        if (goal == GOAL_SPIT && m != MODE_SPITTING)
        begin
            m = MODE_SPITTING;
            if (!held)
                st = now;
        end

        // Shared timeout compare, strict greater on both
        to      = (m == MODE_SPITTING) ? spit_to_reg : intake_to_reg;
        elapsed = now - st;
        expired = (now > st) && (elapsed > time_t'(to));

        unique case (m)
            MODE_IDLE:
            begin
                if (intake_goal)
                begin
                    m  = MODE_INTAKING;
                    st = now;
                end
            end
            MODE_INTAKING:
            begin
                // a fresh intake goal restarts the timer, so no timeout then
                if (intake_goal)
                    st = now;
                if (held)
                    m = MODE_LOADED;
                else if (expired && !intake_goal)
                    m = MODE_IDLE;
                else
                    mv = (pk == PIECE_CUBE) ? cube_suck_reg : cone_suck_reg;
            end
            MODE_LOADED:
            begin
                st = now;
                if (!held && !in_reg.preloaded)
                    m = MODE_INTAKING;
                if (pk != PIECE_CUBE)
                    mv = HOLD_MV;
            end
            MODE_SPITTING:
            begin
                mv = (pk == PIECE_CUBE) ? cube_spit_reg : cone_spit_reg;
                if (held_reg)
                begin
                    if (!held)
                        st = now;
                end
                else if (expired)
                begin
                    m  = MODE_IDLE;
                    pk = PIECE_NONE;
                end
                else if (intake_goal)
                begin
                    m  = MODE_INTAKING;
                    st = now;
                end
            end
        endcase

        mode_next  = m;
        piece_next = pk;
        stamp_next = st;
        held_next  = held;
        mv_next    = mv;
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            piece_reg     <= PIECE_NONE;
            stamp_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg  <= mode_next;
                piece_reg <= piece_next;
                stamp_reg <= stamp_next;
                held_reg  <= held_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mv_reg        <= mv_next;
            mode_out_reg  <= mode_next;
            piece_out_reg <= piece_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.roller_mv = mv_reg;
    assign result.mode_out  = mode_out_reg;
    assign result.piece_out = piece_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ris_checker.sv @@
// Port-level checks on the roller intake sequencer, bound into the sequencer core.
`default_nettype none

module ris_checker
    import ris_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire mv_t        roller_mv,
    input wire logic [1:0] mode_out,
    input wire logic [1:0] piece_out
);

    // Idle with a piece kind still known means intake gave up: roller stopped
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode_out == MODE_IDLE && piece_out != PIECE_NONE |->
            roller_mv == '0)
        else $error("roller driven after intake gave up");

    // Loaded drive is either off or the cone hold drive, never on a cube
    a_hold_drive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode_out == MODE_LOADED |->
            roller_mv == '0 || (piece_out != PIECE_CUBE && roller_mv == HOLD_MV))
        else $error("wrong hold drive in loaded mode");

    // Loaded always knows what it holds
    a_loaded_piece: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode_out == MODE_LOADED |-> piece_out != PIECE_NONE)
        else $error("loaded with no piece kind");

    // A stalled result beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(roller_mv) && $stable(mode_out) && $stable(piece_out))
        else $error("stalled result beat changed");

endmodule

bind roller_intake_sequencer_core ris_checker u_ris_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .roller_mv (result.roller_mv),
    .mode_out  (result.mode_out),
    .piece_out (result.piece_out)
);

`default_nettype wire

@@ tb/sv/tb_roller_intake_sequencer_core.sv @@
// Self-checking testbench for the roller intake sequencer core: directed and random ticks.
module tb_roller_intake_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ris_pkg::*;

    // Expected content of one result beat
    typedef struct packed {
        mv_t    roller_mv;
        mode_t  mode;
        piece_t piece;
    } drive_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    ris_tick_if   tick_ch ();
    ris_result_if result_ch ();

    roller_intake_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Sequencer state and register copy kept by the checker
    mode_t       seq_mode;
    piece_t      seq_piece;
    time_t       seq_stamp;
    bit          seq_last_held;
    logic [11:0] lim_current;
    logic [11:0] lim_position;
    logic [23:0] intake_limit_us;
    logic [23:0] spit_limit_us;
    mv_t         drive_cube_suck;
    mv_t         drive_cone_suck;
    mv_t         drive_cube_spit;
    mv_t         drive_cone_spit;

    tick_t  tick_queue[$];
    drive_t drive_queue[$];
    int     ticks_queued;
    int     ticks_taken;
    int     failures;
    bit     tick_beat_taken;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_request;
    int     hold_left;
    bit     hold_spent;
    time_t  clock_us;
    int     step_max;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    function automatic bit past_deadline(time_t now, time_t since, logic [23:0] span);
        return now > since && (now - since) > {16'd0, span};
    endfunction

    // Advance the sequencer by one tick and return the drive it produces
    function automatic drive_t step_sequencer(tick_t t);
        goal_t  goal;
        bit     intake_goal;
        bit     held;
        mv_t    mv;
        drive_t d;
        goal = (t.goal_code > GOAL_SPIT) ? GOAL_NONE : goal_t'(t.goal_code);
        intake_goal = goal >= GOAL_CONE_UP && goal <= GOAL_LAST;
        mv = '0;

        if (t.preloaded && (seq_mode == MODE_IDLE || seq_mode == MODE_INTAKING))
        begin
            seq_piece = PIECE_CONE_UP;
            seq_mode  = MODE_LOADED;
        end

        case (goal)
            GOAL_CONE_UP:   seq_piece = PIECE_CONE_UP;
            GOAL_CONE_DOWN: seq_piece = PIECE_CONE_DOWN;
            GOAL_CUBE:      seq_piece = PIECE_CUBE;
            default:        ;
        endcase

        held = ((seq_piece == PIECE_CUBE || seq_piece == PIECE_CONE_UP) && t.beam_broken) ||
               (seq_piece == PIECE_CONE_DOWN && t.motor_current > lim_current &&
                t.cone_pos < lim_position);

        if (goal == GOAL_SPIT && seq_mode != MODE_SPITTING)
        begin
            seq_mode = MODE_SPITTING;
            if (!held)
                seq_stamp = t.timestamp;
        end

        case (seq_mode)
            MODE_IDLE:
            begin
                if (intake_goal)
                begin
                    seq_mode  = MODE_INTAKING;
                    seq_stamp = t.timestamp;
                end
            end
            MODE_INTAKING:
            begin
                if (intake_goal)
                    seq_stamp = t.timestamp;
                if (held)
                    seq_mode = MODE_LOADED;
                else if (past_deadline(t.timestamp, seq_stamp, intake_limit_us))
                    seq_mode = MODE_IDLE;
                else
                    mv = (seq_piece == PIECE_CUBE) ? drive_cube_suck : drive_cone_suck;
            end
            MODE_LOADED:
            begin
                seq_stamp = t.timestamp;
                if (!held && !t.preloaded)
                    seq_mode = MODE_INTAKING;
                if (seq_piece != PIECE_CUBE)
                    mv = HOLD_MV;
            end
            default:
            begin
                mv = (seq_piece == PIECE_CUBE) ? drive_cube_spit : drive_cone_spit;
                if (seq_last_held)
                begin
                    if (!held)
                        seq_stamp = t.timestamp;
                end
                else if (past_deadline(t.timestamp, seq_stamp, spit_limit_us))
                begin
                    seq_mode  = MODE_IDLE;
                    seq_piece = PIECE_NONE;
                end
                else if (intake_goal)
                begin
                    seq_mode  = MODE_INTAKING;
                    seq_stamp = t.timestamp;
                end
            end
        endcase

        seq_last_held = held;
        d.roller_mv = mv;
        d.mode      = seq_mode;
        d.piece     = seq_piece;
        return d;
    endfunction

    function automatic tick_t make_tick(time_t ts, logic [2:0] goal, bit pre, bit beam,
                                        logic [11:0] cur, logic [11:0] pos);
        tick_t t;
        t.timestamp     = ts;
        t.goal_code     = goal;
        t.preloaded     = pre;
        t.beam_broken   = beam;
        t.motor_current = cur;
        t.cone_pos      = pos;
        return t;
    endfunction

    // Sensor readings that make a piece of any kind count as held, or not, as far as the limits allow
    function automatic tick_t sensed(time_t ts, logic [2:0] goal, bit pre, bit held);
        logic [11:0] cur;
        logic [11:0] pos;
        if (held)
        begin
            cur = (lim_current < 12'hFFF) ? 12'($urandom_range(4095, lim_current + 1)) : 12'hFFF;
            pos = (lim_position > 0) ? 12'($urandom_range(lim_position - 1, 0)) : 12'd0;
        end
        else if ($urandom_range(1))
        begin
            cur = 12'($urandom_range(lim_current, 0));
            pos = 12'($urandom);
        end
        else
        begin
            cur = 12'($urandom);
            pos = 12'($urandom_range(4095, lim_position));
        end
        return make_tick(ts, goal, pre, held, cur, pos);
    endfunction

    function automatic mv_t rand_mv();
        int v;
        v = int'($urandom_range(32000)) - 16000;
        return mv_t'(v);
    endfunction

    task automatic add_tick(tick_t t);
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CURRENT_THRESHOLD: lim_current     = data[11:0];
            REG_POSITION_LIMIT:    lim_position    = data[11:0];
            REG_INTAKE_TIMEOUT:    intake_limit_us = data[23:0];
            REG_SPIT_TIMEOUT:      spit_limit_us   = data[23:0];
            REG_CUBE_SUCK_MV:      drive_cube_suck = data[MV_BITS-1:0];
            REG_CONE_SUCK_MV:      drive_cone_suck = data[MV_BITS-1:0];
            REG_CUBE_SPIT_MV:      drive_cube_spit = data[MV_BITS-1:0];
            default:               drive_cone_spit = data[MV_BITS-1:0];
        endcase
    endtask

    task automatic set_limits(int thr, int pos, int intake_us, int spit_us);
        write_reg(REG_CURRENT_THRESHOLD, CFG_BITS'(thr));
        write_reg(REG_POSITION_LIMIT, CFG_BITS'(pos));
        write_reg(REG_INTAKE_TIMEOUT, CFG_BITS'(intake_us));
        write_reg(REG_SPIT_TIMEOUT, CFG_BITS'(spit_us));
    endtask

    task automatic set_drives(mv_t cube_suck, mv_t cone_suck, mv_t cube_spit, mv_t cone_spit);
        write_reg(REG_CUBE_SUCK_MV, {{(CFG_BITS-MV_BITS){cube_suck[MV_BITS-1]}}, cube_suck});
        write_reg(REG_CONE_SUCK_MV, {{(CFG_BITS-MV_BITS){cone_suck[MV_BITS-1]}}, cone_suck});
        write_reg(REG_CUBE_SPIT_MV, {{(CFG_BITS-MV_BITS){cube_spit[MV_BITS-1]}}, cube_spit});
        write_reg(REG_CONE_SPIT_MV, {{(CFG_BITS-MV_BITS){cone_spit[MV_BITS-1]}}, cone_spit});
    endtask

    // Wait until every queued tick is taken and answered
    task automatic settle();
        while (ticks_taken != ticks_queued || drive_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One intake-hold-spit cycle with random content
    task automatic add_episode();
        logic [2:0] goal;
        int         n;
        goal = 3'($urandom_range(4, 1));
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
        begin
            clock_us += $urandom_range(step_max);
            add_tick(sensed(clock_us, (i == 0 || $urandom_range(1)) ? goal : GOAL_NONE,
                            1'b0, $urandom_range(5) == 0));
        end
        // sometimes sit around the intake deadline
        if ($urandom_range(3) == 0)
        begin
            clock_us += intake_limit_us + $urandom_range(2);
            add_tick(sensed(clock_us, GOAL_NONE, 1'b0, 1'b0));
        end
        if ($urandom_range(9) == 0)
        begin
            clock_us += $urandom_range(step_max);
            add_tick(sensed(clock_us, GOAL_NONE, 1'b1, $urandom_range(1)));
        end
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
        begin
            clock_us += $urandom_range(step_max);
            add_tick(sensed(clock_us, $urandom_range(2) == 0 ? goal : GOAL_NONE,
                            1'b0, $urandom_range(7) != 0));
        end
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
        begin
            clock_us += $urandom_range(step_max);
            add_tick(sensed(clock_us, GOAL_SPIT, 1'b0, $urandom_range(3) != 0));
        end
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
        begin
            clock_us += $urandom_range(spit_limit_us / 2 + step_max);
            add_tick(sensed(clock_us, $urandom_range(5) == 0 ? goal : GOAL_NONE,
                            1'b0, $urandom_range(5) == 0));
        end
    endtask

    // Random phase: well-formed episodes with some raw noise mixed in
    task automatic add_random_phase(int count);
        int          first;
        logic [63:0] r;
        first = ticks_queued;
        while (ticks_queued - first < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                r = {$urandom, $urandom};
                add_tick(make_tick($urandom_range(1) ? r[39:0] : clock_us, 3'($urandom),
                                   $urandom_range(3) == 0, $urandom_range(1),
                                   12'($urandom), 12'($urandom)));
            end
            else
                add_episode();
        end
    endtask

    // Tick driver: new beat at the falling edge once the previous one is taken
    always @(negedge clk)
    begin : drive_ticks
        tick_t nxt;
        if (!rst_n)
            tick_ch.valid <= 1'b0;
        else if (!tick_ch.valid || tick_beat_taken)
        begin
            if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = tick_queue.pop_front();
                tick_ch.valid         <= 1'b1;
                tick_ch.timestamp     <= nxt.timestamp;
                tick_ch.goal_code     <= nxt.goal_code;
                tick_ch.preloaded     <= nxt.preloaded;
                tick_ch.beam_broken   <= nxt.beam_broken;
                tick_ch.motor_current <= nxt.motor_current;
                tick_ch.cone_pos      <= nxt.cone_pos;
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_request && !hold_spent)
        begin
            hold_left       <= 80;
            hold_spent      <= 1'b1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on each taken tick, check each taken result
    always @(posedge clk)
    begin : watch_beats
        tick_t  seen;
        drive_t want;
        if (!rst_n)
            tick_beat_taken <= 1'b0;
        else
        begin
            tick_beat_taken <= tick_ch.valid && tick_ch.ready;
            if (tick_ch.valid && tick_ch.ready)
            begin
                seen = make_tick(tick_ch.timestamp, tick_ch.goal_code, tick_ch.preloaded,
                                 tick_ch.beam_broken, tick_ch.motor_current, tick_ch.cone_pos);
                drive_queue.push_back(step_sequencer(seen));
                ticks_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (drive_queue.size() == 0)
                begin
                    $display("%0t: result beat with none expected (mv %0d mode %0d piece %0d)",
                             $realtime, result_ch.roller_mv, result_ch.mode_out,
                             result_ch.piece_out);
                    failures++;
                end
                else
                begin
                    want = drive_queue.pop_front();
                    if (result_ch.roller_mv !== want.roller_mv)
                    begin
                        $display("%0t: roller_mv expected %0d actual %0d", $realtime,
                                 want.roller_mv, result_ch.roller_mv);
                        failures++;
                    end
                    if (result_ch.mode_out !== want.mode)
                    begin
                        $display("%0t: mode_out expected %0d actual %0d", $realtime,
                                 want.mode, result_ch.mode_out);
                        failures++;
                    end
                    if (result_ch.piece_out !== want.piece)
                    begin
                        $display("%0t: piece_out expected %0d actual %0d", $realtime,
                                 want.piece, result_ch.piece_out);
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        tick_ch.valid         = 1'b0;
        tick_ch.timestamp     = '0;
        tick_ch.goal_code     = '0;
        tick_ch.preloaded     = 1'b0;
        tick_ch.beam_broken   = 1'b0;
        tick_ch.motor_current = '0;
        tick_ch.cone_pos      = '0;
        result_ch.ready       = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        ticks_queued          = 0;
        ticks_taken           = 0;
        failures              = 0;
        hold_request          = 1'b0;
        hold_left             = 0;
        hold_spent            = 1'b0;
        send_idle_pct         = 0;
        recv_idle_pct         = 0;
        step_max              = 50;

        // Reset values of the state and registers
        seq_mode        = MODE_IDLE;
        seq_piece       = PIECE_NONE;
        seq_stamp       = '0;
        seq_last_held   = 1'b0;
        lim_current     = 12'd400;
        lim_position    = 12'd3768;
        intake_limit_us = 24'd2000000;
        spit_limit_us   = 24'd0;
        drive_cube_suck = '0;
        drive_cone_suck = '0;
        drive_cube_spit = '0;
        drive_cone_spit = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk through every mode and goal
        set_limits(400, 3768, 1000, 200);
        set_drives(15'sd5000, -15'sd7000, 15'sd12000, -15'sd3000);
        add_tick(make_tick(40'd100, GOAL_NONE, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd110, 3'd6, 0, 1, 12'd4095, 12'd0));
        add_tick(make_tick(40'd120, 3'd7, 0, 1, 12'd4095, 12'd0));
        // intake last with no piece kind uses the cone suck drive
        add_tick(make_tick(40'd130, GOAL_LAST, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd140, GOAL_LAST, 0, 0, 12'd0, 12'd4095));
        add_tick(make_tick(40'd150, GOAL_CUBE, 0, 1, 12'd0, 12'd0));
        add_tick(make_tick(40'd160, GOAL_NONE, 0, 1, 12'd0, 12'd0));
        add_tick(make_tick(40'd170, GOAL_SPIT, 0, 1, 12'd0, 12'd0));
        add_tick(make_tick(40'd180, GOAL_NONE, 0, 0, 12'd0, 12'd0));
        // spit deadline: equal is not past, one more is
        add_tick(make_tick(40'd380, GOAL_NONE, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd381, GOAL_NONE, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd400, GOAL_CONE_DOWN, 0, 0, 12'd4095, 12'd0));
        add_tick(make_tick(40'd410, GOAL_CONE_DOWN, 0, 0, 12'd4095, 12'd0));
        add_tick(make_tick(40'd420, GOAL_NONE, 0, 0, 12'd400, 12'd0));
        // intake deadline, same strict compare
        add_tick(make_tick(40'd1420, GOAL_NONE, 0, 0, 12'd4095, 12'd3768));
        add_tick(make_tick(40'd1421, GOAL_NONE, 0, 0, 12'd4095, 12'd3768));
        add_tick(make_tick(40'd1430, GOAL_NONE, 1, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd1440, GOAL_SPIT, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd1450, GOAL_CONE_UP, 0, 0, 12'd0, 12'd0));
        // a timestamp below the stamp never times out
        add_tick(make_tick(40'd5, GOAL_NONE, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'hFF_FFFF_FFFF, GOAL_NONE, 0, 0, 12'd0, 12'd0));
        add_tick(make_tick(40'd0, GOAL_CUBE, 1, 1, 12'd4095, 12'd4095));
        add_tick(make_tick(40'd1, GOAL_SPIT, 1, 0, 12'd4095, 12'd4095));
        settle();

        // Sender mostly busy, receiver mostly stalled
        clock_us      = 40'd1000;
        step_max      = 80;
        send_idle_pct = 6;
        recv_idle_pct = 64;
        set_limits(400, 3768, 300, 50);
        set_drives(rand_mv(), rand_mv(), rand_mv(), rand_mv());
        add_random_phase(135);
        settle();

        // Extremes: widest held window for a downward cone, zero timeouts
        send_idle_pct = 64;
        recv_idle_pct = 6;
        step_max      = 3;
        set_limits(0, 4095, 0, 0);
        set_drives(-15'sd16000, 15'sd16000, -15'sd16000, 15'sd16000);
        add_random_phase(135);
        settle();

        // Other extremes, no idling, one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        step_max      = 1 << 22;
        set_limits(4095, 0, 16777215, 16777215);
        set_drives(15'sd16000, -15'sd16000, 15'sd16000, -15'sd16000);
        add_random_phase(135);
        hold_request = 1'b1;
        settle();

        // Random register settings
        clock_us = 40'd5000;
        step_max = $urandom_range(2000, 1);
        set_limits($urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4000), $urandom_range(1000));
        set_drives(rand_mv(), rand_mv(), rand_mv(), rand_mv());
        add_random_phase(135);
        settle();

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
